// ===== sv/rcu_gpt_pkg.sv =====
`default_nettype none

package rcu_gpt_pkg;

    localparam int unsigned OP_W   = 3;
    localparam int unsigned CORE_W = 3;
    localparam int unsigned ERR_W  = 2;
    localparam int unsigned CFG_W  = 4;
    localparam int unsigned GEN_OUT_W  = 64;
    localparam int unsigned NEST_OUT_W = 8;

    localparam logic [OP_W-1:0] OP_READ_LOCK   = 3'd0;
    localparam logic [OP_W-1:0] OP_READ_UNLOCK = 3'd1;
    localparam logic [OP_W-1:0] OP_QUIESCE     = 3'd2;
    localparam logic [OP_W-1:0] OP_SYNCHRONIZE = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK        = 3'd4;

    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_UNLOCK    = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NEST_SAT  = 2'd2;

    localparam logic [CFG_W-1:0] ACTIVE_CORES_RESET = 4'd8;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [CORE_W-1:0] core_id;
    } t_in_word;

    typedef struct packed {
        logic [ERR_W-1:0]      error_code;
        logic [GEN_OUT_W-1:0]  generation;
        logic                  grace_done;
        logic [GEN_OUT_W-1:0]  completed_generation;
        logic                  grace_pending;
        logic                  core_quiescent;
        logic [NEST_OUT_W-1:0] core_nesting;
    } t_out_word;

endpackage

`default_nettype wire

// ===== sv/rcu_grace_period_tracker.sv =====
// Channel   Direction  Handshake                Word
// in        input      i_valid / o_stall        i_word  (operation, core_id)
// out       output     o_valid / i_stall        o_word  (error, generations, core status)
// cfg       input      i_cfg_valid / o_cfg_ready i_cfg_data (active_cores)
//
// One word per cycle sustained while i_stall is low: an input register feeds
// one pass of logic (core entry update, generation increment, per-core seen
// compare) into the output register, which drives o_valid.
// Synchronous active-low reset clears all tracker state; active_cores resets to 8.
// o_stall rises only when the input register is full and the output register
// is held by i_stall. The cfg port is always ready.
`default_nettype none

module rcu_grace_period_tracker #(
    parameter int unsigned NUM_CORES     = 8,
    parameter int unsigned NESTING_WIDTH = 8,
    parameter int unsigned GEN_WIDTH     = 64
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_valid,
    output logic                                o_stall,
    input  wire  rcu_gpt_pkg::t_in_word         i_word,
    output logic                                o_valid,
    input  wire                                 i_stall,
    output rcu_gpt_pkg::t_out_word              o_word,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [rcu_gpt_pkg::CFG_W-1:0]       i_cfg_data
);

    localparam int unsigned IDX_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;

    // pipeline control
    logic                           r_in_valid;
    rcu_gpt_pkg::t_in_word          r_in;
    logic                           r_out_valid;
    rcu_gpt_pkg::t_out_word         r_out;
    logic                           advance;
    logic                           in_ready;

    // tracker state
    logic [rcu_gpt_pkg::CFG_W-1:0]  r_active_cores;
    logic [GEN_WIDTH-1:0]           r_gen;
    logic [GEN_WIDTH-1:0]           r_gen_plus;
    logic [GEN_WIDTH-1:0]           r_tick_last;
    logic [GEN_WIDTH-1:0]           r_target;
    logic                           r_pending;
    logic [GEN_WIDTH-1:0]           r_seen  [NUM_CORES];
    logic [NESTING_WIDTH-1:0]       r_nest  [NUM_CORES];
    logic                           r_quiet [NUM_CORES];

    // step logic
    logic                           core_ok;
    logic [IDX_W-1:0]               idx;
    logic [NESTING_WIDTH-1:0]       cur_nest;
    logic                           cur_quiet;
    logic [NESTING_WIDTH-1:0]       nest_new;
    logic                           quiet_new;
    logic                           seen_wr;
    logic [rcu_gpt_pkg::ERR_W-1:0]  err;
    logic                           start;
    logic                           tick_rec;
    logic [GEN_WIDTH-1:0]           n_gen;
    logic [GEN_WIDTH-1:0]           n_gen_plus;
    logic [GEN_WIDTH-1:0]           n_target;
    logic                           pend_pre;
    logic                           all_caught_up;
    logic                           done;
    logic                           n_pending;
    logic [GEN_WIDTH-1:0]           seen_chk;
    logic [GEN_WIDTH-1:0]           diff;
    rcu_gpt_pkg::t_out_word         n_out;

    assign advance     = r_in_valid && (!r_out_valid || !i_stall);
    assign in_ready    = !r_in_valid || advance;
    assign o_stall     = !in_ready;
    assign o_valid     = r_out_valid;
    assign o_word      = r_out;
    assign o_cfg_ready = 1'b1;

    assign core_ok   = int'(r_in.core_id) < NUM_CORES;
    assign idx       = IDX_W'(r_in.core_id);
    assign cur_nest  = r_nest[idx];
    assign cur_quiet = r_quiet[idx];

    always_comb begin
        nest_new = cur_nest;
        quiet_new = cur_quiet;
        seen_wr  = 1'b0;
        err      = rcu_gpt_pkg::ERR_NONE;
        start    = 1'b0;
        tick_rec = 1'b0;
        unique case (r_in.operation)
            rcu_gpt_pkg::OP_READ_LOCK: begin
                if (core_ok) begin
                    if (cur_nest == {NESTING_WIDTH{1'b1}}) begin
                        err = rcu_gpt_pkg::ERR_NEST_SAT;
                    end else begin
                        nest_new = cur_nest + 1'b1;
                        if (cur_nest == '0) begin
                            quiet_new = 1'b0;
                        end
                    end
                end
            end
            rcu_gpt_pkg::OP_READ_UNLOCK: begin
                if (core_ok) begin
                    if (cur_nest == '0) begin
                        err = rcu_gpt_pkg::ERR_UNLOCK;
                    end else begin
                        nest_new = cur_nest - 1'b1;
                        if (cur_nest == NESTING_WIDTH'(1)) begin
                            quiet_new = 1'b1;
                            seen_wr   = 1'b1;
                        end
                    end
                end
            end
            rcu_gpt_pkg::OP_QUIESCE: begin
                if (core_ok) begin
                    quiet_new = 1'b1;
                    seen_wr   = 1'b1;
                end
            end
            rcu_gpt_pkg::OP_SYNCHRONIZE: begin
                start = 1'b1;
            end
            rcu_gpt_pkg::OP_TICK: begin
                if (r_gen != r_tick_last) begin
                    tick_rec = 1'b1;
                end else begin
                    start = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // r_gen_plus holds r_gen + 1 so a grace start needs no adder in the compare path
    assign n_gen      = start ? r_gen_plus : r_gen;
    assign n_gen_plus = n_gen + 1'b1;
    assign n_target   = start ? r_gen_plus : r_target;
    assign pend_pre   = start || r_pending;

    // wrap-safe: seen - target must land in the lower half of the ring
    always_comb begin
        all_caught_up = 1'b1;
        seen_chk = '0;
        diff     = '0;
        for (int i = 0; i < NUM_CORES; i++) begin
            seen_chk = (seen_wr && core_ok && idx == IDX_W'(i)) ? r_gen : r_seen[i];
            diff     = seen_chk - n_target;
            if (i < int'(r_active_cores) && diff[GEN_WIDTH-1]) begin
                all_caught_up = 1'b0;
            end
        end
    end

    assign done      = pend_pre && all_caught_up;
    assign n_pending = pend_pre && !all_caught_up;

    always_comb begin
        n_out.error_code           = err;
        n_out.generation           = rcu_gpt_pkg::GEN_OUT_W'(n_gen);
        n_out.grace_done           = done;
        n_out.completed_generation = done ? rcu_gpt_pkg::GEN_OUT_W'(n_target) : '0;
        n_out.grace_pending        = n_pending;
        n_out.core_quiescent       = core_ok && quiet_new;
        n_out.core_nesting         = core_ok ? rcu_gpt_pkg::NEST_OUT_W'(nest_new) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
            r_active_cores <= rcu_gpt_pkg::ACTIVE_CORES_RESET;
            r_gen          <= '0;
            r_gen_plus     <= GEN_WIDTH'(1);
            r_tick_last    <= '0;
            r_target       <= '0;
            r_pending      <= 1'b0;
            for (int i = 0; i < NUM_CORES; i++) begin
                r_seen[i]  <= '0;
                r_nest[i]  <= '0;
                r_quiet[i] <= 1'b1;
            end
        end else begin
            if (in_ready) begin
                r_in_valid <= i_valid;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_active_cores <= i_cfg_data;
            end
            if (advance) begin
                r_gen      <= n_gen;
                r_gen_plus <= n_gen_plus;
                r_target   <= n_target;
                r_pending  <= n_pending;
                if (tick_rec) begin
                    r_tick_last <= r_gen;
                end
                if (core_ok) begin
                    r_nest[idx]  <= nest_new;
                    r_quiet[idx] <= quiet_new;
                    if (seen_wr) begin
                        r_seen[idx] <= r_gen;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_valid) begin
            r_in <= i_word;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && r_out_valid && i_stall))
        else $error("input stalled without a blocked word");

    a_unlock_err_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.error_code == rcu_gpt_pkg::ERR_UNLOCK)
            |-> (r_out.core_nesting == '0))
        else $error("unlock error reported with nonzero depth");

    a_pending_rise_gen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_pending) |-> (r_gen == $past(r_gen_plus) && r_target == r_gen))
        else $error("grace period started without generation advance");

endmodule

`default_nettype wire

// ===== test/rcu_grace_period_tracker_tb.sv =====
`timescale 1ns / 100ps

module rcu_grace_period_tracker_tb;

    localparam int unsigned CORES       = 8;
    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam int unsigned HOLD_CYCLES = 80;
    localparam logic [rcu_gpt_pkg::NEST_OUT_W-1:0] NEST_LIMIT  = 8'hFF;
    localparam logic [rcu_gpt_pkg::OP_W-1:0]       OP_UNUSED_5 = 3'd5;
    localparam logic [rcu_gpt_pkg::OP_W-1:0]       OP_UNUSED_6 = 3'd6;
    localparam logic [rcu_gpt_pkg::OP_W-1:0]       OP_UNUSED_7 = 3'd7;

    // Mirrors the tracker state and keeps the words still owed by the block.
    class grace_tracker_model;
        logic [63:0]          generation_now;
        logic [63:0]          tick_generation;
        logic [63:0]          target;
        bit                   waiting;
        logic [63:0]          seen[CORES];
        logic [rcu_gpt_pkg::NEST_OUT_W-1:0] depth[CORES];
        bit                   quiet[CORES];
        logic [rcu_gpt_pkg::CFG_W-1:0] active_cores;
        rcu_gpt_pkg::t_out_word awaited_words[$];
        int                   mismatches;
        int                   words_in;
        int                   completions;
        int                   saturations;
        int                   unlock_errors;

        function new();
            generation_now  = '0;
            tick_generation = '0;
            target          = '0;
            waiting         = 0;
            active_cores    = rcu_gpt_pkg::ACTIVE_CORES_RESET;
            mismatches      = 0;
            words_in        = 0;
            completions     = 0;
            saturations     = 0;
            unlock_errors   = 0;
            for (int i = 0; i < CORES; i++) begin
                seen[i]  = '0;
                depth[i] = '0;
                quiet[i] = 1;
            end
        endfunction

        function void open_grace_period();
            generation_now = generation_now + 64'd1;
            target         = generation_now;
            waiting        = 1;
        endfunction

        function void note_input(rcu_gpt_pkg::t_in_word w);
            rcu_gpt_pkg::t_out_word r;
            int unsigned c;
            int unsigned n;
            bit          caught_up;
            logic [63:0] lag;
            r = '0;
            c = w.core_id;
            words_in++;
            case (w.operation)
                rcu_gpt_pkg::OP_READ_LOCK: begin
                    if (depth[c] == NEST_LIMIT) begin
                        r.error_code = rcu_gpt_pkg::ERR_NEST_SAT;
                        saturations++;
                    end else begin
                        if (depth[c] == 0)
                            quiet[c] = 0;
                        depth[c] = depth[c] + 1'b1;
                    end
                end
                rcu_gpt_pkg::OP_READ_UNLOCK: begin
                    if (depth[c] == 0) begin
                        r.error_code = rcu_gpt_pkg::ERR_UNLOCK;
                        unlock_errors++;
                    end else begin
                        depth[c] = depth[c] - 1'b1;
                        if (depth[c] == 0) begin
                            quiet[c] = 1;
                            seen[c]  = generation_now;
                        end
                    end
                end
                rcu_gpt_pkg::OP_QUIESCE: begin
                    quiet[c] = 1;
                    seen[c]  = generation_now;
                end
                rcu_gpt_pkg::OP_SYNCHRONIZE: open_grace_period();
                rcu_gpt_pkg::OP_TICK: begin
                    if (generation_now != tick_generation)
                        tick_generation = generation_now;
                    else
                        open_grace_period();
                end
                default: ;
            endcase
            if (waiting) begin
                n = (active_cores > CORES) ? CORES : active_cores;
                caught_up = 1;
                for (int i = 0; i < n; i++) begin
                    lag = seen[i] - target;
                    // wrap-safe: seen is at or past target when the difference is "positive"
                    if (lag[63])
                        caught_up = 0;
                end
                if (caught_up) begin
                    r.grace_done           = 1;
                    r.completed_generation = target;
                    waiting                = 0;
                    completions++;
                end
            end
            r.generation     = generation_now;
            r.grace_pending  = waiting;
            r.core_quiescent = quiet[c];
            r.core_nesting   = depth[c];
            awaited_words.push_back(r);
        endfunction

        function void compare_field(string label, logic [63:0] want, logic [63:0] got);
            if (want !== got) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, label, want, got);
            end
        endfunction

        function void check_result(rcu_gpt_pkg::t_out_word got);
            rcu_gpt_pkg::t_out_word want;
            if (awaited_words.size() == 0) begin
                mismatches++;
                $display("%0t: result word with nothing expected, actual %h", $time, got);
                return;
            end
            want = awaited_words.pop_front();
            compare_field("error_code", want.error_code, got.error_code);
            compare_field("generation", want.generation, got.generation);
            compare_field("grace_done", want.grace_done, got.grace_done);
            compare_field("completed_generation", want.completed_generation,
                          got.completed_generation);
            compare_field("grace_pending", want.grace_pending, got.grace_pending);
            compare_field("core_quiescent", want.core_quiescent, got.core_quiescent);
            compare_field("core_nesting", want.core_nesting, got.core_nesting);
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_stall;
    rcu_gpt_pkg::t_in_word         i_word;
    logic                          o_valid;
    logic                          i_stall;
    rcu_gpt_pkg::t_out_word        o_word;
    logic                          i_cfg_valid;
    logic                          o_cfg_ready;
    logic [rcu_gpt_pkg::CFG_W-1:0] i_cfg_data;

    grace_tracker_model    tracker;
    rcu_gpt_pkg::t_in_word planned_words[$];
    int                    burst_left;
    bit                    hold_request;
    int                    cycle_count;

    rcu_grace_period_tracker uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_word     (i_word),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_word     (o_word),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("rcu_grace_period_tracker_tb: FAIL");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            tracker.check_result(o_word);
    end

    // Receiver: segments of varying stall density, plus one long hold-off on request.
    initial begin
        int hold_left;
        int seg_left;
        int stall_pct;
        hold_left = 0;
        seg_left  = 0;
        stall_pct = 0;
        i_stall <= 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_stall <= 1;
            end else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(5, 40);
                    case ($urandom_range(0, 3))
                        0: stall_pct = 0;
                        1: stall_pct = 25;
                        2: stall_pct = 50;
                        default: stall_pct = 80;
                    endcase
                end
                seg_left--;
                i_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    function automatic void queue_word(logic [rcu_gpt_pkg::OP_W-1:0] op,
                                       logic [rcu_gpt_pkg::CORE_W-1:0] core);
        rcu_gpt_pkg::t_in_word w;
        w.operation = op;
        w.core_id   = core;
        planned_words.push_back(w);
    endfunction

    function automatic void queue_noise();
        queue_word(rcu_gpt_pkg::OP_W'($urandom_range(0, 7)),
                   rcu_gpt_pkg::CORE_W'($urandom_range(0, 7)));
    endfunction

    // A grace period opened, then most cores pass a quiescent point, with noise mixed in.
    function automatic void plan_episode();
        int          noise;
        int          start;
        int          pick;
        logic [rcu_gpt_pkg::CORE_W-1:0] c;
        noise = $urandom_range(0, 4);
        repeat (noise) queue_noise();
        queue_word($urandom_range(0, 1) ? rcu_gpt_pkg::OP_SYNCHRONIZE : rcu_gpt_pkg::OP_TICK,
                   rcu_gpt_pkg::CORE_W'($urandom_range(0, 7)));
        start = $urandom_range(0, CORES - 1);
        for (int k = 0; k < CORES; k++) begin
            c    = rcu_gpt_pkg::CORE_W'((start + k) % CORES);
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                queue_word(rcu_gpt_pkg::OP_QUIESCE, c);
            end else if (pick < 90) begin
                queue_word(rcu_gpt_pkg::OP_READ_LOCK, c);
                queue_word(rcu_gpt_pkg::OP_READ_UNLOCK, c);
            end else if (pick < 95) begin
                queue_word(rcu_gpt_pkg::OP_READ_UNLOCK, c);
            end
            if ($urandom_range(0, 5) == 0)
                queue_noise();
        end
    endfunction

    task automatic send_word(rcu_gpt_pkg::t_in_word w);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
        burst_left--;
        if (gap > 0) begin
            i_valid <= 0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1;
        i_word  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        tracker.note_input(w);
    endtask

    task automatic send_planned();
        while (planned_words.size() > 0)
            send_word(planned_words.pop_front());
    endtask

    // Always waits on the clock before checking, so valid is never lowered and raised in one step.
    task automatic wait_idle();
        i_valid <= 0;
        do @(posedge i_clk); while (tracker.awaited_words.size() > 0);
    endtask

    task automatic write_active_cores(logic [rcu_gpt_pkg::CFG_W-1:0] value);
        i_cfg_valid <= 1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
        tracker.active_cores = value;
    endtask

    task automatic run_random(int count, bit pause_mid);
        int sent;
        sent = 0;
        while (sent < count || planned_words.size() > 0) begin
            if (planned_words.size() == 0)
                plan_episode();
            send_word(planned_words.pop_front());
            sent++;
            if (pause_mid && sent == count / 2)
                wait_idle();
        end
    endtask

    initial begin
        logic [rcu_gpt_pkg::CFG_W-1:0] phase_cores[6];
        tracker      = new();
        burst_left   = 0;
        hold_request = 0;
        cycle_count  = 0;
        i_rst_n     <= 0;
        i_valid     <= 0;
        i_word      <= '0;
        i_cfg_valid <= 0;
        i_cfg_data  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: unlock with no lock, nesting, tick recording then acting,
        // synchronize absorbing an older wait, quiesce inside a section
        queue_word(rcu_gpt_pkg::OP_READ_UNLOCK, 3'd0);
        queue_word(rcu_gpt_pkg::OP_READ_LOCK, 3'd0);
        queue_word(rcu_gpt_pkg::OP_READ_LOCK, 3'd0);
        queue_word(rcu_gpt_pkg::OP_READ_UNLOCK, 3'd0);
        queue_word(rcu_gpt_pkg::OP_READ_UNLOCK, 3'd0);
        queue_word(rcu_gpt_pkg::OP_QUIESCE, 3'd7);
        queue_word(rcu_gpt_pkg::OP_SYNCHRONIZE, 3'd0);
        queue_word(rcu_gpt_pkg::OP_TICK, 3'd1);
        queue_word(rcu_gpt_pkg::OP_TICK, 3'd2);
        queue_word(rcu_gpt_pkg::OP_SYNCHRONIZE, 3'd3);
        queue_word(rcu_gpt_pkg::OP_READ_LOCK, 3'd4);
        queue_word(rcu_gpt_pkg::OP_QUIESCE, 3'd4);
        for (int c = 0; c < CORES; c++)
            if (c != 4)
                queue_word(rcu_gpt_pkg::OP_QUIESCE, rcu_gpt_pkg::CORE_W'(c));
        queue_word(rcu_gpt_pkg::OP_READ_UNLOCK, 3'd4);
        queue_word(OP_UNUSED_5, 3'd0);
        queue_word(OP_UNUSED_6, 3'd5);
        queue_word(OP_UNUSED_7, 3'd7);
        send_planned();

        // no active cores: completes on the synchronize itself
        wait_idle();
        write_active_cores(4'd0);
        queue_word(rcu_gpt_pkg::OP_SYNCHRONIZE, 3'd2);
        queue_word(rcu_gpt_pkg::OP_TICK, 3'd6);
        send_planned();

        // above the core count, then shrink so an idle step completes the wait
        wait_idle();
        write_active_cores(4'd15);
        queue_word(rcu_gpt_pkg::OP_SYNCHRONIZE, 3'd1);
        queue_word(rcu_gpt_pkg::OP_QUIESCE, 3'd0);
        send_planned();
        wait_idle();
        write_active_cores(4'd1);
        queue_word(OP_UNUSED_7, 3'd3);
        send_planned();

        // nesting saturation on one core and the way back down
        wait_idle();
        write_active_cores(4'd8);
        repeat (257) queue_word(rcu_gpt_pkg::OP_READ_LOCK, 3'd5);
        repeat (256) queue_word(rcu_gpt_pkg::OP_READ_UNLOCK, 3'd5);
        send_planned();

        phase_cores[0] = 4'd1;
        phase_cores[1] = 4'd8;
        phase_cores[2] = 4'd3;
        phase_cores[3] = 4'd0;
        phase_cores[4] = 4'd15;
        phase_cores[5] = rcu_gpt_pkg::CFG_W'($urandom_range(1, 8));
        for (int p = 0; p < 6; p++) begin
            wait_idle();
            write_active_cores(phase_cores[p]);
            if (p == 1)
                hold_request = 1;
            run_random(60, p == 2);
        end

        wait_idle();
        repeat (10) @(posedge i_clk);
        $display("covered %0d input words, active_cores 0, 1, 3, 8, 15 and one random value",
                 tracker.words_in);
        $display("%0d grace periods completed, %0d saturated locks, %0d unlocks without lock",
                 tracker.completions, tracker.saturations, tracker.unlock_errors);
        if (tracker.mismatches == 0 && tracker.awaited_words.size() == 0) begin
            $display("rcu_grace_period_tracker_tb: PASS");
        end else begin
            $display("rcu_grace_period_tracker_tb: FAIL");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rcu_gpt_pkg.sv
sv/rcu_grace_period_tracker.sv
test/rcu_grace_period_tracker_tb.sv
